// ===== rtl/rcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared types and constants for the rc pwm pulse width decoder.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int LEVELS_DEF   = 1024;

  // register map (index of the register, byte address is 4 * index)
  localparam logic [0:0] REG_NOMINAL_MAX = 1'b0;

  localparam logic [15:0] NOMINAL_RESET = 16'd4000;

  // n / 100 == (n * RECIP_K) >> RECIP_SH for every 16-bit n
  localparam logic [16:0] RECIP_K  = 17'd83887;
  localparam int          RECIP_SH = 23;

  localparam int TS_W    = 32;
  localparam int NOM_W   = 16;
  localparam int HALF_W  = 15;
  localparam int WIDTH_W = 16;
  localparam int LIMIT_W = 17;
  localparam int VAL_W   = 10;

  typedef enum logic [1:0] {
    OP_RISE    = 2'd0,
    OP_FALL    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LIMIT,
    ST_MULT,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/rc_pwm_pulse_width_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_pwm_pulse_width_decoder
// Multi-channel rc pwm receiver: edge timestamps in, scaled stick values out.
// ----------------------------------------------------------------------------
// Rising and falling edge transactions store the timestamp for their
// channel. A compute transaction checks the pulse against the limit
// N + (N/100)*10; if it passes, the excess over N/2 is multiplied by
// LEVELS-1 into a DVD_W = 16 + log2(LEVELS) bit product, and a serial
// divider produces one quotient bit per cycle. A rejected compute gives no
// result, and an accepted one with N/2 of zero skips the divider.
// A compute that finds the output register still holding an untaken result
// waits until it is taken. The input is not ready while a compute runs.
// Results go through an output register, so a pending result does not stall
// edge transactions. A compute always clears both stored times of its
// channel; opcode three and channels at or above CHANNELS are ignored.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_decoder #(
  parameter int CHANNELS = rcpwm_pkg::CHANNELS_DEF,
  parameter int LEVELS   = rcpwm_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] timestamp
  input  logic [3:0]  in_tuser,   // [1:0] opcode, [3:2] channel
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] channel_value, [15:10] zero
  output logic [1:0]  out_tuser,  // [1:0] out_channel
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TOP_W  = $clog2(LEVELS);
  localparam int DVD_W  = rcpwm_pkg::WIDTH_W + TOP_W;
  localparam logic [TOP_W-1:0] TOP = TOP_W'(LEVELS - 1);

  rcpwm_pkg::state_t state_r, state_nxt;

  logic [rcpwm_pkg::TS_W-1:0]    rise_r [CHANNELS];
  logic [rcpwm_pkg::TS_W-1:0]    fall_r [CHANNELS];
  logic [rcpwm_pkg::NOM_W-1:0]   nominal_r;

  logic [rcpwm_pkg::TS_W-1:0]    t1_r, t1_nxt;
  logic [rcpwm_pkg::TS_W-1:0]    t2_r, t2_nxt;
  logic [1:0]                    ch_r, ch_nxt;
  logic                          gt_r, gt_nxt;
  logic [rcpwm_pkg::WIDTH_W-1:0] w_r, w_nxt;
  logic [32:0]                   recip_r, recip_nxt;
  logic [rcpwm_pkg::WIDTH_W-1:0] diff_r, diff_nxt;
  logic [DVD_W-1:0]              prod_r, prod_nxt;
  logic [TOP_W-1:0]              res_r, res_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_ch_r, out_ch_nxt;
  logic [TOP_W-1:0]              out_val_r, out_val_nxt;

  rcpwm_pkg::opcode_t            in_op;
  logic [1:0]                    in_ch;
  logic [CH_W-1:0]               in_idx;
  logic                          in_ch_ok;
  logic                          in_acc;
  logic                          store_rise, store_fall, store_clear;

  logic [rcpwm_pkg::HALF_W-1:0]  half;
  logic [9:0]                    n_div100;
  logic [rcpwm_pkg::LIMIT_W-1:0] limit;
  logic [rcpwm_pkg::WIDTH_W-1:0] w_clamped;
  logic                          cfg_wr;

  logic                          div_start;
  rcpwm_pkg::div_status_t        div_status;
  logic [DVD_W-1:0]              div_quo;
  logic [31:0]                   val_ext;

  assign in_op    = rcpwm_pkg::opcode_t'(in_tuser[1:0]);
  assign in_ch    = in_tuser[3:2];
  assign in_idx   = CH_W'(in_ch);
  assign in_ch_ok = 5'(in_ch) < 5'(CHANNELS);
  assign in_tready = (state_r == rcpwm_pkg::ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  assign store_rise  = in_acc && in_ch_ok && (in_op == rcpwm_pkg::OP_RISE);
  assign store_fall  = in_acc && in_ch_ok && (in_op == rcpwm_pkg::OP_FALL);
  assign store_clear = in_acc && in_ch_ok && (in_op == rcpwm_pkg::OP_COMPUTE);

  assign half     = nominal_r[rcpwm_pkg::NOM_W-1:1];
  assign n_div100 = recip_r[rcpwm_pkg::RECIP_SH +: 10];
  assign limit    = rcpwm_pkg::LIMIT_W'(nominal_r)
                  + rcpwm_pkg::LIMIT_W'({n_div100, 3'b000})
                  + rcpwm_pkg::LIMIT_W'({n_div100, 1'b0});
  assign w_clamped = (w_r < rcpwm_pkg::WIDTH_W'(half)) ? rcpwm_pkg::WIDTH_W'(half) : w_r;

  assign div_start = (state_r == rcpwm_pkg::ST_START);

  rcpwm_div #(
    .DVD_W (DVD_W),
    .DVS_W (rcpwm_pkg::HALF_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (half),
    .status   (div_status),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    ch_nxt        = ch_r;
    gt_nxt        = gt_r;
    w_nxt         = w_r;
    recip_nxt     = recip_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_ch_nxt    = out_ch_r;
    out_val_nxt   = out_val_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      rcpwm_pkg::ST_IDLE: begin
        if (store_clear) begin
          t1_nxt    = rise_r[in_idx];
          t2_nxt    = fall_r[in_idx];
          ch_nxt    = in_ch;
          state_nxt = rcpwm_pkg::ST_CHECK;
        end
      end
      rcpwm_pkg::ST_CHECK: begin
        gt_nxt    = t2_r > t1_r;
        w_nxt     = rcpwm_pkg::WIDTH_W'(t2_r - t1_r);
        recip_nxt = nominal_r * rcpwm_pkg::RECIP_K;
        state_nxt = rcpwm_pkg::ST_LIMIT;
      end
      rcpwm_pkg::ST_LIMIT: begin
        diff_nxt = w_clamped - rcpwm_pkg::WIDTH_W'(half);
        if (!gt_r || (rcpwm_pkg::LIMIT_W'(w_r) > limit)) begin
          state_nxt = rcpwm_pkg::ST_IDLE;
        end else if (half == '0) begin
          res_nxt   = TOP;
          state_nxt = rcpwm_pkg::ST_DONE;
        end else begin
          state_nxt = rcpwm_pkg::ST_MULT;
        end
      end
      rcpwm_pkg::ST_MULT: begin
        prod_nxt  = diff_r * TOP;
        state_nxt = rcpwm_pkg::ST_START;
      end
      rcpwm_pkg::ST_START: begin
        state_nxt = rcpwm_pkg::ST_DIV;
      end
      rcpwm_pkg::ST_DIV: begin
        if (div_status.done) begin
          res_nxt   = (div_quo > DVD_W'(TOP)) ? TOP : div_quo[TOP_W-1:0];
          state_nxt = rcpwm_pkg::ST_DONE;
        end
      end
      rcpwm_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_val_nxt   = res_r;
          state_nxt     = rcpwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rcpwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcpwm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t1_r      <= t1_nxt;
    t2_r      <= t2_nxt;
    ch_r      <= ch_nxt;
    gt_r      <= gt_nxt;
    w_r       <= w_nxt;
    recip_r   <= recip_nxt;
    diff_r    <= diff_nxt;
    prod_r    <= prod_nxt;
    res_r     <= res_nxt;
    out_ch_r  <= out_ch_nxt;
    out_val_r <= out_val_nxt;
  end

  // per-channel edge timestamps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_r[i] <= '0;
        fall_r[i] <= '0;
      end
    end else begin
      if (store_rise) begin
        rise_r[in_idx] <= in_tdata;
      end
      if (store_fall) begin
        fall_r[in_idx] <= in_tdata;
      end
      if (store_clear) begin
        rise_r[in_idx] <= '0;
        fall_r[in_idx] <= '0;
      end
    end
  end

  // configuration register
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == rcpwm_pkg::REG_NOMINAL_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= rcpwm_pkg::NOMINAL_RESET;
    end else if (cfg_wr) begin
      nominal_r <= cfg_pwdata[rcpwm_pkg::NOM_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rcpwm_pkg::REG_NOMINAL_MAX) ?
                      32'(nominal_r) : 32'd0;

  assign val_ext    = 32'(out_val_r);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ch_r;
  assign out_tdata  = {6'd0, val_ext[rcpwm_pkg::VAL_W-1:0]};

endmodule

// ===== rtl/rcpwm_div.sv =====
// ----------------------------------------------------------------------------
// rcpwm_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcpwm_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DVD_W-1:0]         dividend,
  input  logic [DVS_W-1:0]         divisor,
  output rcpwm_pkg::div_status_t   status,
  output logic [DVD_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in DVS_W bits
      rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// ===== dv/rc_pwm_pulse_width_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_pwm_pulse_width_decoder_tb
// Self-checking bench: edge and compute transactions in, stick values checked.
// ----------------------------------------------------------------------------
// A short directed table covers the scale extremes, the limit, timestamps near
// the top, width truncation, equal edges and the ignored opcode, some rows with
// fixed expected values. Random pulse sequences follow under several full-scale
// settings, down to 16 and up to the largest; a behavioral decoder predicts
// them. The sender works in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_decoder_tb;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 238;
  localparam int TOP_LEVEL     = rcpwm_pkg::LEVELS_DEF - 1;

  typedef struct {
    logic [1:0]                  ch;
    logic [rcpwm_pkg::VAL_W-1:0] value;
  } stick_t;

  typedef enum {CHK_PRED, CHK_NONE, CHK_VALUE} chk_kind_t;

  typedef struct {
    rcpwm_pkg::opcode_t op;
    logic [1:0]         ch;
    logic [31:0]        ts;
    chk_kind_t          kind;
    int                 value;
  } pulse_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] timestamp
  logic [3:0]  in_tuser;   // [1:0] opcode, [3:2] channel
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [9:0] channel_value, [15:10] zero
  logic [1:0]  out_tuser;  // [1:0] out_channel
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // decoder state mirrored by the bench
  logic [31:0] rise_ts [rcpwm_pkg::CHANNELS_DEF];
  logic [31:0] fall_ts [rcpwm_pkg::CHANNELS_DEF];
  logic [15:0] full_scale;
  stick_t      stick_q [$];

  int errors       = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int stall_cycles = 0;
  int ready_mode   = 0;
  int ready_left   = 0;

  pulse_row_t dir_rows [22] = '{
    '{rcpwm_pkg::OP_COMPUTE, 2'd0, 32'd0,          CHK_NONE,  0},
    '{rcpwm_pkg::OP_RISE,    2'd0, 32'd1000,       CHK_PRED,  0},
    '{rcpwm_pkg::OP_FALL,    2'd0, 32'd5000,       CHK_PRED,  0},
    '{rcpwm_pkg::OP_COMPUTE, 2'd0, 32'd0,          CHK_VALUE, 1023},
    '{rcpwm_pkg::OP_RISE,    2'd1, 32'd0,          CHK_PRED,  0},
    '{rcpwm_pkg::OP_FALL,    2'd1, 32'd2000,       CHK_PRED,  0},
    '{rcpwm_pkg::OP_COMPUTE, 2'd1, 32'd0,          CHK_VALUE, 0},
    '{rcpwm_pkg::OP_RISE,    2'd2, 32'hFFFF_F000,  CHK_PRED,  0},
    '{rcpwm_pkg::OP_FALL,    2'd2, 32'hFFFF_FFFF,  CHK_PRED,  0},
    '{rcpwm_pkg::OP_COMPUTE, 2'd2, 32'hFFFF_FFFF,  CHK_VALUE, 1023},
    '{rcpwm_pkg::OP_RISE,    2'd3, 32'd100,        CHK_PRED,  0},
    '{rcpwm_pkg::OP_FALL,    2'd3, 32'd4501,       CHK_PRED,  0},
    '{rcpwm_pkg::OP_COMPUTE, 2'd3, 32'd0,          CHK_NONE,  0},
    '{rcpwm_pkg::OP_RISE,    2'd0, 32'd5000,       CHK_PRED,  0},
    '{rcpwm_pkg::OP_FALL,    2'd0, 32'd5000,       CHK_PRED,  0},
    '{rcpwm_pkg::OP_NONE,    2'd0, 32'hFFFF_FFFF,  CHK_PRED,  0},
    '{rcpwm_pkg::OP_COMPUTE, 2'd0, 32'd0,          CHK_NONE,  0},
    '{rcpwm_pkg::OP_RISE,    2'd1, 32'd0,          CHK_PRED,  0},
    '{rcpwm_pkg::OP_FALL,    2'd1, 32'h0001_0BB8,  CHK_PRED,  0},
    '{rcpwm_pkg::OP_COMPUTE, 2'd1, 32'd0,          CHK_VALUE, 511},
    '{rcpwm_pkg::OP_FALL,    2'd2, 32'd3000,       CHK_PRED,  0},
    '{rcpwm_pkg::OP_COMPUTE, 2'd2, 32'd0,          CHK_VALUE, 511}
  };

  rc_pwm_pulse_width_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // updates the mirrored state; returns 1 when a stick value comes out
  function automatic bit decode_pulse(rcpwm_pkg::opcode_t op, logic [1:0] ch,
                                      logic [31:0] ts,
                                      output logic [rcpwm_pkg::VAL_W-1:0] value);
    logic [31:0]     t_rise;
    logic [31:0]     t_fall;
    int unsigned     n;
    int unsigned     half;
    int unsigned     limit;
    int unsigned     width;
    longint unsigned q;
    bit              produced;
    produced = 1'b0;
    value    = '0;
    case (op)
      rcpwm_pkg::OP_RISE: rise_ts[ch] = ts;
      rcpwm_pkg::OP_FALL: fall_ts[ch] = ts;
      rcpwm_pkg::OP_COMPUTE: begin
        t_rise      = rise_ts[ch];
        t_fall      = fall_ts[ch];
        rise_ts[ch] = '0;
        fall_ts[ch] = '0;
        n     = full_scale;
        half  = n / 2;
        limit = n + (n / 100) * 10;
        width = (t_fall - t_rise) & 32'h0000_FFFF;
        if (t_fall > t_rise && width <= limit) begin
          produced = 1'b1;
          if (half == 0) begin
            q = TOP_LEVEL;
          end else begin
            if (width < half) width = half;
            q = (longint'(width - half) * TOP_LEVEL) / half;
            if (q > TOP_LEVEL) q = TOP_LEVEL;
          end
          value = q[rcpwm_pkg::VAL_W-1:0];
        end
      end
      default: ;
    endcase
    return produced;
  endfunction

  task automatic send_item(rcpwm_pkg::opcode_t op, logic [1:0] ch, logic [31:0] ts,
                           chk_kind_t kind = CHK_PRED, int typed = 0);
    logic [rcpwm_pkg::VAL_W-1:0] value;
    bit                          produced;
    int                          gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 250)
                                                : $urandom_range(1, 16);
      gap = $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ts;
    in_tuser  <= {ch, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    produced = decode_pulse(op, ch, ts, value);
    if (kind == CHK_VALUE) stick_q.push_back('{ch, rcpwm_pkg::VAL_W'(typed)});
    else if (kind == CHK_PRED && produced) stick_q.push_back('{ch, value});
    if (op != rcpwm_pkg::OP_NONE) items_sent++;
  endtask

  // hold the input until every stick value is out, then let a rejected compute finish
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (stick_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_full_scale(logic [15:0] n);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {rcpwm_pkg::REG_NOMINAL_MAX, 2'b00};
    cfg_pwdata  <= 32'(n);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    full_scale = n;
  endtask

  // width around the acceptance window, with the odd wrap or negative span
  function automatic logic [31:0] pulse_len(int unsigned n, int unsigned lim);
    logic [31:0] len;
    case ($urandom_range(0, 9))
      6: begin
        case ($urandom_range(0, 3))
          0: len = n / 2;
          1: len = lim;
          2: len = lim + 1;
          default: len = n;
        endcase
      end
      7: len = $urandom_range(lim, 65535) + ($urandom_range(1, 3) << 16);
      8: len = -$urandom_range(0, 1000);
      9: len = $urandom;
      default: len = $urandom_range(0, lim + lim / 8 + 1);
    endcase
    return len;
  endfunction

  task automatic run_random(int count);
    int          stop_at;
    logic [1:0]  ch;
    logic [31:0] rise;
    int unsigned n;
    int unsigned lim;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      ch   = 2'($urandom_range(0, 3));
      n    = full_scale;
      lim  = n + (n / 100) * 10;
      rise = $urandom;
      case ($urandom_range(0, 9))
        0: send_item(rcpwm_pkg::opcode_t'($urandom_range(0, 3)), ch, $urandom);
        1: begin
          // broken sequences: a missing edge, a lone compute or no compute
          case ($urandom_range(0, 3))
            0: send_item(rcpwm_pkg::OP_RISE, ch, rise);
            1: send_item(rcpwm_pkg::OP_FALL, ch, rise + pulse_len(n, lim));
            2: ;
            default: begin
              send_item(rcpwm_pkg::OP_RISE, ch, rise);
              send_item(rcpwm_pkg::OP_FALL, ch, rise + pulse_len(n, lim));
            end
          endcase
          send_item(($urandom_range(0, 3) == 0) ? rcpwm_pkg::OP_RISE : rcpwm_pkg::OP_COMPUTE,
                    ch, $urandom);
        end
        default: begin
          send_item(rcpwm_pkg::OP_RISE, ch, rise);
          if ($urandom_range(0, 7) == 0)
            send_item(rcpwm_pkg::opcode_t'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)), $urandom);
          send_item(rcpwm_pkg::OP_FALL, ch, rise + pulse_len(n, lim));
          send_item(rcpwm_pkg::OP_COMPUTE, ch, $urandom);
        end
      endcase
      if ($urandom_range(0, 399) == 0) drain_results();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    stick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (stick_q.size() == 0) begin
        $error("unexpected transaction: out_channel %0d channel_value %0d",
               out_tuser, out_tdata[rcpwm_pkg::VAL_W-1:0]);
        errors++;
      end else begin
        want = stick_q.pop_front();
        if (out_tuser != want.ch) begin
          $error("out_channel: expected %0d, got %0d", want.ch, out_tuser);
          errors++;
        end
        if (out_tdata[rcpwm_pkg::VAL_W-1:0] != want.value) begin
          $error("channel_value: expected %0d, got %0d", want.value,
                 out_tdata[rcpwm_pkg::VAL_W-1:0]);
          errors++;
        end
      end
    end
  end

  // receiver: stretches of always ready, coin flips and long stalls
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(30, 300);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[rc_pwm_pulse_width_decoder] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    foreach (rise_ts[i]) begin
      rise_ts[i] = '0;
      fall_ts[i] = '0;
    end
    full_scale = rcpwm_pkg::NOMINAL_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].ts, dir_rows[i].kind,
                dir_rows[i].value);
    run_random(PHASE_ITEMS);

    write_full_scale(16'd16);
    run_random(PHASE_ITEMS);
    write_full_scale(16'hFFFF);
    run_random(PHASE_ITEMS);
    write_full_scale(16'($urandom_range(16, 65535)));
    run_random(PHASE_ITEMS);
    write_full_scale(16'($urandom_range(16, 300)));
    run_random(PHASE_ITEMS);
    write_full_scale(rcpwm_pkg::NOMINAL_RESET);
    run_random(PHASE_ITEMS);

    drain_results();
    if (errors == 0) begin
      $display("[rc_pwm_pulse_width_decoder] OK");
    end else begin
      $display("[rc_pwm_pulse_width_decoder] ERROR");
    end
    $finish;
  end

endmodule
